// ===== rtl/voxel_dilate_six_neighbour_macros.svh =====
// Assertion helpers used by the asserting top-level file.
`ifndef VOXEL_DILATE_SIX_NEIGHBOUR_MACROS_SVH
`define VOXEL_DILATE_SIX_NEIGHBOUR_MACROS_SVH

// Same-cycle implication under the active-low synchronous reset.
`define VDIL_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low synchronous reset.
`define VDIL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vdil_pkg.sv =====
package vdil_pkg;

    localparam int LABEL_BITS = 7;
    localparam int FACE_COUNT = 6;
    localparam int WORD_W     = LABEL_BITS + 1;   // label bits plus the grow mark on top
    localparam int SIZE_W     = 6;
    localparam int COORD_W    = 5;
    localparam int BIT_SEL_W  = 3;
    localparam int COUNT_W    = 16;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Face walk order: center first, then the six face neighbours.
    localparam logic [2:0] FACE_CENTER = 3'd0;
    localparam logic [2:0] FACE_XN     = 3'd1;
    localparam logic [2:0] FACE_XP     = 3'd2;
    localparam logic [2:0] FACE_YN     = 3'd3;
    localparam logic [2:0] FACE_YP     = 3'd4;
    localparam logic [2:0] FACE_ZN     = 3'd5;
    localparam logic [2:0] FACE_ZP     = 3'd6;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DILATE = 2'd2
    } action_t;

    typedef struct packed {
        logic [BIT_SEL_W-1:0]  guard_bit;
        logic [BIT_SEL_W-1:0]  label_bit;
        logic [LABEL_BITS-1:0] write_bits;
        logic [COORD_W-1:0]    coord_z;
        logic [COORD_W-1:0]    coord_y;
        logic [COORD_W-1:0]    coord_x;
        action_t               action;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    grown_count;
        logic                  status;
        logic [LABEL_BITS-1:0] read_bits;
    } res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] x;
        logic [SIZE_W-1:0] y;
        logic [SIZE_W-1:0] z;
    } dims_t;

    // One-hot mask of a label bit; selector seven gives an empty mask.
    function automatic logic [LABEL_BITS-1:0] bit_mask(input logic [BIT_SEL_W-1:0] sel);
        bit_mask = LABEL_BITS'(8'b1 << sel);
    endfunction

endpackage

// ===== rtl/vdil_voxel_ram.sv =====
module vdil_voxel_ram import vdil_pkg::*; #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/vdil_seq.sv =====
module vdil_seq import vdil_pkg::*; #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int AW    = 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              in_cmd,
    input  dims_t             dims,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [WORD_W-1:0] mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [WORD_W-1:0] mem_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECODE    = 8'b0000_0010,
        S_READ_WAIT = 8'b0000_0100,
        S_SCAN_RD   = 8'b0000_1000,
        S_SCAN_CHK  = 8'b0001_0000,
        S_APPLY_RD  = 8'b0010_0000,
        S_APPLY_CHK = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    localparam logic [AW-1:0] MX_A  = AW'(MAX_X);
    localparam logic [AW-1:0] MXY_A = AW'(MAX_X * MAX_Y);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    res_t                  res_reg, res_next;
    logic [SIZE_W-1:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [AW-1:0]         addr_reg, addr_next, row_reg, row_next, plane_reg, plane_next;
    logic [2:0]            face_reg, face_next;
    logic [LABEL_BITS-1:0] center_reg, center_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [LABEL_BITS-1:0] lmask, gmask, rd_bits;
    logic                  coord_ok, face_ok, off_sub, advance;
    logic                  x_last, y_last, z_last, scan_end;
    logic [AW-1:0]         coord_addr, off, nbr_addr, row_step, plane_step;

    assign lmask   = bit_mask(cmd_reg.label_bit);
    assign gmask   = bit_mask(cmd_reg.guard_bit);
    assign rd_bits = mem_rdata[LABEL_BITS-1:0];

    assign coord_ok = ({1'b0, cmd_reg.coord_x} < dims.x) &&
                      ({1'b0, cmd_reg.coord_y} < dims.y) &&
                      ({1'b0, cmd_reg.coord_z} < dims.z);
    assign coord_addr = AW'(cmd_reg.coord_x) + MX_A * AW'(cmd_reg.coord_y) +
                        MXY_A * AW'(cmd_reg.coord_z);

    assign x_last   = !((x_reg + SIZE_W'(1)) < dims.x);
    assign y_last   = !((y_reg + SIZE_W'(1)) < dims.y);
    assign z_last   = !((z_reg + SIZE_W'(1)) < dims.z);
    assign scan_end = x_last && y_last && z_last;

    assign row_step   = row_reg + MX_A;
    assign plane_step = plane_reg + MXY_A;

    // Neighbour address unit: one adder, offset and direction picked by face.
    always_comb begin
        face_ok = 1'b1;
        off     = '0;
        off_sub = 1'b0;
        case (face_reg)
            FACE_XN: begin
                face_ok = (x_reg != '0);
                off     = AW'(1);
                off_sub = 1'b1;
            end
            FACE_XP: begin
                face_ok = !x_last;
                off     = AW'(1);
            end
            FACE_YN: begin
                face_ok = (y_reg != '0);
                off     = MX_A;
                off_sub = 1'b1;
            end
            FACE_YP: begin
                face_ok = !y_last;
                off     = MX_A;
            end
            FACE_ZN: begin
                face_ok = (z_reg != '0);
                off     = MXY_A;
                off_sub = 1'b1;
            end
            FACE_ZP: begin
                face_ok = !z_last;
                off     = MXY_A;
            end
            default: begin
                face_ok = 1'b1;
                off     = '0;
            end
        endcase
    end

    assign nbr_addr = off_sub ? (addr_reg - off) : (addr_reg + off);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        addr_next   = addr_reg;
        row_next    = row_reg;
        plane_next  = plane_reg;
        face_next   = face_reg;
        center_next = center_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = '0;
        mem_raddr   = nbr_addr;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        advance     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next   = '0;
                state_next = S_DONE;
                unique case (cmd_reg.action)
                    ACT_WRITE: begin
                        if (coord_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = coord_addr;
                            mem_wdata = {1'b0, cmd_reg.write_bits};
                        end else begin
                            res_next.status = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        mem_raddr = coord_addr;
                        if (coord_ok) begin
                            state_next = S_READ_WAIT;
                        end else begin
                            res_next.status = 1'b1;
                        end
                    end
                    ACT_DILATE: begin
                        x_next     = '0;
                        y_next     = '0;
                        z_next     = '0;
                        addr_next  = '0;
                        row_next   = '0;
                        plane_next = '0;
                        face_next  = FACE_CENTER;
                        count_next = '0;
                        // empty volume: nothing to walk
                        if (dims.x != '0 && dims.y != '0 && dims.z != '0) begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                res_next.read_bits = rd_bits;
                state_next         = S_DONE;
            end
            S_SCAN_RD: begin
                if (face_ok) begin
                    state_next = S_SCAN_CHK;
                end else if (face_reg == FACE_ZP) begin
                    advance = 1'b1;
                end else begin
                    face_next = face_reg + 3'd1;
                end
            end
            S_SCAN_CHK: begin
                if (face_reg == FACE_CENTER) begin
                    center_next = rd_bits;
                    if ((rd_bits & (lmask | gmask)) != '0) begin
                        advance = 1'b1;
                    end else begin
                        face_next  = FACE_XN;
                        state_next = S_SCAN_RD;
                    end
                end else if ((rd_bits & lmask) != '0) begin
                    // mark only; label bits stay as they were until the apply walk
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, center_reg};
                    advance   = 1'b1;
                end else if (face_reg == FACE_ZP) begin
                    advance = 1'b1;
                end else begin
                    face_next  = face_reg + 3'd1;
                    state_next = S_SCAN_RD;
                end
            end
            S_APPLY_RD: begin
                mem_raddr  = addr_reg;
                state_next = S_APPLY_CHK;
            end
            S_APPLY_CHK: begin
                if (mem_rdata[WORD_W-1]) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b0, rd_bits | lmask};
                    if (count_reg != '1) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                advance = 1'b1;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next voxel in x, then y, then z order.
        if (advance) begin
            face_next = FACE_CENTER;
            if (!x_last) begin
                x_next    = x_reg + SIZE_W'(1);
                addr_next = addr_reg + AW'(1);
            end else if (!y_last) begin
                x_next    = '0;
                y_next    = y_reg + SIZE_W'(1);
                row_next  = row_step;
                addr_next = row_step;
            end else if (!z_last) begin
                x_next     = '0;
                y_next     = '0;
                z_next     = z_reg + SIZE_W'(1);
                plane_next = plane_step;
                row_next   = plane_step;
                addr_next  = plane_step;
            end else begin
                x_next     = '0;
                y_next     = '0;
                z_next     = '0;
                plane_next = '0;
                row_next   = '0;
                addr_next  = '0;
            end

            if (state_reg == S_APPLY_CHK) begin
                if (scan_end) begin
                    res_next.grown_count = count_next;
                    state_next           = S_DONE;
                end else begin
                    state_next = S_APPLY_RD;
                end
            end else begin
                state_next = scan_end ? S_APPLY_RD : S_SCAN_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        addr_reg   <= addr_next;
        row_reg    <= row_next;
        plane_reg  <= plane_next;
        face_reg   <= face_next;
        center_reg <= center_next;
        count_reg  <= count_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/voxel_dilate_six_neighbour.sv =====
// Channel  | Handshake                 | Payload
// s_       | s_tvalid / s_tready       | s_tdata: action, coord_x/y/z, write_bits, label/guard
// m_       | m_tvalid / m_tready       | m_tdata: read_bits, status, grown_count
// cfg_     | cfg_wr_en (no back-press) | cfg_wr_index, cfg_wr_data: size_x/y/z
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Write passes S_DECODE and S_DONE; a read adds S_READ_WAIT for the registered RAM read. Dilate: each
// center, with its in-range neighbours up to a labelled one if it has neither label nor guard bit, is
// read (S_SCAN_RD) and checked (S_SCAN_CHK) through the RAM read port; an apply walk then reads and
// checks each voxel (S_APPLY_RD, S_APPLY_CHK). The output register lets the next item in while a
// result waits for m_tready. aresetn is synchronous; the voxel RAM is not cleared by it.
`include "voxel_dilate_six_neighbour_macros.svh"

module voxel_dilate_six_neighbour import vdil_pkg::*; #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] action, [6:2] coord_x, [11:7] coord_y, [16:12] coord_z,
    // [23:17] write_bits, [26:24] label_bit, [29:27] guard_bit, [31:30] zero
    input  logic [31:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [6:0] read_bits, [7] status, [23:8] grown_count
    output logic [23:0]          m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  logic [SIZE_W-1:0]    cfg_wr_data
);

    localparam int VOL = MAX_X * MAX_Y * MAX_Z;
    localparam int AW  = $clog2(VOL);

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    dims_t             dims;
    cmd_t              in_cmd;
    res_t              res;
    res_t              m_tdata_reg;
    logic              m_tvalid_reg;
    logic              res_valid, res_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(32);
            size_y_reg <= SIZE_W'(32);
            size_z_reg <= SIZE_W'(32);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SIZE_X: size_x_reg <= cfg_wr_data;
                REG_SIZE_Y: size_y_reg <= cfg_wr_data;
                REG_SIZE_Z: size_z_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Clip the size registers to the built volume.
    assign dims.x = (int'(size_x_reg) < MAX_X) ? size_x_reg : SIZE_W'(MAX_X);
    assign dims.y = (int'(size_y_reg) < MAX_Y) ? size_y_reg : SIZE_W'(MAX_Y);
    assign dims.z = (int'(size_z_reg) < MAX_Z) ? size_z_reg : SIZE_W'(MAX_Z);

    assign in_cmd = s_tdata[$bits(cmd_t)-1:0];

    vdil_seq #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .AW    (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .dims      (dims),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    vdil_voxel_ram #(
        .DEPTH (VOL),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Output register: take a result whenever the slot is empty or draining.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `VDIL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while an item is still in work")
    `VDIL_ASSERT_NOW(a_result_from_seq, aclk, aresetn, $rose(m_tvalid_reg), $past(res_valid), "output valid without a finished item")
    `VDIL_ASSERT_NOW(a_count_only_fields, aclk, aresetn, m_tvalid_reg && (m_tdata_reg.grown_count != '0), (m_tdata_reg.status == 1'b0) && (m_tdata_reg.read_bits == '0), "dilate result carries read fields")
    `VDIL_ASSERT_NOW(a_ram_write_busy, aclk, aresetn, mem_we, !s_tready, "voxel RAM written while idle")

endmodule

// ===== tb/voxel_dilate_six_neighbour_tb.sv =====
`timescale 1ns / 1ps

import vdil_pkg::*;

class voxel_scoreboard;
    localparam int DIM = 32;
    localparam int VOL = DIM * DIM * DIM;

    logic [LABEL_BITS-1:0] voxel_bits [VOL];
    bit                    grow_mark  [VOL];
    logic [SIZE_W-1:0]     size_reg   [3];
    res_t                  expected_q [$];
    int                    error_count;
    int                    result_count;

    function new();
        foreach (voxel_bits[i]) begin
            voxel_bits[i] = '0;
            grow_mark[i]  = 1'b0;
        end
        foreach (size_reg[i]) size_reg[i] = 6'd32;
        error_count  = 0;
        result_count = 0;
    endfunction

    function int active_len(int axis);
        return (size_reg[axis] < DIM) ? int'(size_reg[axis]) : DIM;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void set_size(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        case (idx)
            REG_SIZE_X: size_reg[0] = val;
            REG_SIZE_Y: size_reg[1] = val;
            REG_SIZE_Z: size_reg[2] = val;
            default: ;
        endcase
    endfunction

    function int vox_index(int x, int y, int z);
        return x + DIM * (y + DIM * z);
    endfunction

    // Selector seven names no stored bit.
    function bit holds(logic [LABEL_BITS-1:0] v, logic [BIT_SEL_W-1:0] sel);
        return (sel < 3'd7) ? v[sel] : 1'b0;
    endfunction

    function logic [COUNT_W-1:0] dilation_pass(logic [BIT_SEL_W-1:0] label,
                                               logic [BIT_SEL_W-1:0] guard);
        int ex, ey, ez, i;
        bit hit;
        logic [COUNT_W-1:0] grown;
        ex = active_len(0);
        ey = active_len(1);
        ez = active_len(2);
        grown = '0;
        // Mark against the pre-pass volume first, then apply.
        for (int z = 0; z < ez; z++)
            for (int y = 0; y < ey; y++)
                for (int x = 0; x < ex; x++) begin
                    i = vox_index(x, y, z);
                    if (!holds(voxel_bits[i], label) && !holds(voxel_bits[i], guard)) begin
                        hit = (x > 0      && holds(voxel_bits[i-1], label))
                           || (x + 1 < ex && holds(voxel_bits[i+1], label))
                           || (y > 0      && holds(voxel_bits[i-DIM], label))
                           || (y + 1 < ey && holds(voxel_bits[i+DIM], label))
                           || (z > 0      && holds(voxel_bits[i-DIM*DIM], label))
                           || (z + 1 < ez && holds(voxel_bits[i+DIM*DIM], label));
                        if (hit) grow_mark[i] = 1'b1;
                    end
                end
        for (int z = 0; z < ez; z++)
            for (int y = 0; y < ey; y++)
                for (int x = 0; x < ex; x++) begin
                    i = vox_index(x, y, z);
                    if (grow_mark[i]) begin
                        grow_mark[i]  = 1'b0;
                        voxel_bits[i] = voxel_bits[i] | LABEL_BITS'(8'd1 << label);
                        if (grown != 16'hFFFF) grown++;
                    end
                end
        return grown;
    endfunction

    function void note_input(cmd_t c);
        res_t r;
        bit   in_range;
        r = '0;
        in_range = (c.coord_x < active_len(0)) && (c.coord_y < active_len(1))
                && (c.coord_z < active_len(2));
        case (c.action)
            ACT_WRITE: begin
                if (!in_range) r.status = 1'b1;
                else voxel_bits[vox_index(c.coord_x, c.coord_y, c.coord_z)] = c.write_bits;
            end
            ACT_READ: begin
                if (!in_range) r.status = 1'b1;
                else r.read_bits = voxel_bits[vox_index(c.coord_x, c.coord_y, c.coord_z)];
            end
            ACT_DILATE: r.grown_count = dilation_pass(c.label_bit, c.guard_bit);
            default: ;
        endcase
        expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch on result %0d: %s", $time, result_count, msg);
        error_count++;
    endtask

    task check_result(res_t got);
        res_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("no result expected, got %h", got));
        end else begin
            want = expected_q.pop_front();
            if (got.read_bits !== want.read_bits)
                report($sformatf("read_bits %h, want %h", got.read_bits, want.read_bits));
            if (got.status !== want.status)
                report($sformatf("status %b, want %b", got.status, want.status));
            if (got.grown_count !== want.grown_count)
                report($sformatf("grown_count %0d, want %0d",
                                 got.grown_count, want.grown_count));
        end
        result_count++;
    endtask
endclass

module voxel_dilate_six_neighbour_tb;
    localparam logic [1:0]           ACT_UNUSED  = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int ITEM_TARGET = 1250;
    // Dilated volumes hold at most 48 voxels; the limit only catches a hung run.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int END_SETTLE  = 16;

    localparam int RX_OPEN  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_BEAT  = 2;
    localparam int RX_CHOKE = 3;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata      = '0;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_wr_en    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_wr_index = '0;
    logic [SIZE_W-1:0]    cfg_wr_data  = '0;

    voxel_scoreboard sb = new();

    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int stall_mode  = RX_OPEN;
    int mode_left   = 0;
    int tick        = 0;

    voxel_dilate_six_neighbour u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("voxel_dilate_six_neighbour regression: fail");
            $finish;
        end
    end

    // Result side: check on transfer, then pick next ready from the current stall mode.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(res_t'(m_tdata));
        if (mode_left == 0) begin
            stall_mode = $urandom_range(RX_OPEN, RX_CHOKE);
            mode_left  = $urandom_range(16, 160);
        end
        mode_left--;
        tick++;
        case (stall_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            RX_BEAT: m_tready <= (tick % 4) != 0;
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic cmd_t make_cmd(logic [1:0] act, int x, int y, int z,
                                      int bits, int label, int guard);
        cmd_t c;
        c.action     = action_t'(act);
        c.coord_x    = COORD_W'(x);
        c.coord_y    = COORD_W'(y);
        c.coord_z    = COORD_W'(z);
        c.write_bits = LABEL_BITS'(bits);
        c.label_bit  = BIT_SEL_W'(label);
        c.guard_bit  = BIT_SEL_W'(guard);
        return c;
    endfunction

    function automatic int pick_coord(int len);
        if (len == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, len - 1);
    endfunction

    // Mix dense, sparse and extreme label patterns so passes keep growing.
    function automatic int voxel_pattern();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return 0;
        if (roll == 1) return 127;
        if (roll < 9) return $urandom_range(0, 127);
        return $urandom_range(0, 127) & $urandom_range(0, 127);
    endfunction

    function automatic cmd_t random_item();
        logic [29:0] raw;
        cmd_t c;
        int roll, g;
        raw = 30'($urandom);
        c = cmd_t'(raw);
        c.coord_x = COORD_W'(pick_coord(sb.active_len(0)));
        c.coord_y = COORD_W'(pick_coord(sb.active_len(1)));
        c.coord_z = COORD_W'(pick_coord(sb.active_len(2)));
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            c.action     = ACT_WRITE;
            c.write_bits = LABEL_BITS'(voxel_pattern());
        end else if (roll < 70) begin
            c.action = ACT_READ;
        end else if (roll < 93) begin
            c.action    = ACT_DILATE;
            c.label_bit = ($urandom_range(0, 9) == 0) ? 3'd7 : BIT_SEL_W'($urandom_range(0, 6));
            g = $urandom_range(0, 9);
            if (g < 2) c.guard_bit = 3'd7;
            else if (g == 2) c.guard_bit = c.label_bit;
            else c.guard_bit = BIT_SEL_W'($urandom_range(0, 6));
        end else begin
            c.action = action_t'(ACT_UNUSED);
        end
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(c);
        if (c.action != ACT_UNUSED) items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        sb.set_size(idx, val);
        @(posedge aclk);
    endtask

    task automatic write_sizes(input int sx, input int sy, input int sz);
        write_reg(REG_SIZE_X, SIZE_W'(sx));
        write_reg(REG_SIZE_Y, SIZE_W'(sy));
        write_reg(REG_SIZE_Z, SIZE_W'(sz));
        // The spare index must be ignored.
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, SIZE_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Fill the whole active volume before anything can read it, then randomize.
    task automatic run_phase(input int sx, input int sy, input int sz, input int n_random);
        wait_idle();
        write_sizes(sx, sy, sz);
        for (int z = 0; z < sb.active_len(2); z++)
            for (int y = 0; y < sb.active_len(1); y++)
                for (int x = 0; x < sb.active_len(0); x++)
                    send_cmd(make_cmd(ACT_WRITE, x, y, z, voxel_pattern(),
                                      $urandom_range(0, 7), $urandom_range(0, 7)));
        repeat (n_random) send_cmd(random_item());
    endtask

    initial begin
        int sx, sy, sz, lim, axis, big;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Full reset volume: edge voxels, each read after its write, then an unused action.
        send_cmd(make_cmd(ACT_WRITE, 0, 0, 0, 127, 0, 0));
        send_cmd(make_cmd(ACT_WRITE, 31, 31, 31, 0, 7, 7));
        send_cmd(make_cmd(ACT_WRITE, 5, 31, 0, 'h2A, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 31, 31, 31, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 5, 31, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_UNUSED, 31, 31, 31, 127, 7, 7));

        wait_idle();
        write_sizes(2, 2, 1);
        send_cmd(make_cmd(ACT_WRITE, 0, 0, 0, 'h01, 0, 0));
        send_cmd(make_cmd(ACT_WRITE, 1, 0, 0, 'h00, 0, 0));
        send_cmd(make_cmd(ACT_WRITE, 0, 1, 0, 'h40, 0, 0));
        send_cmd(make_cmd(ACT_WRITE, 1, 1, 0, 'h02, 0, 0));
        send_cmd(make_cmd(ACT_DILATE, 0, 0, 0, 0, 0, 7));
        send_cmd(make_cmd(ACT_DILATE, 0, 0, 0, 0, 7, 0));
        send_cmd(make_cmd(ACT_DILATE, 0, 0, 0, 0, 1, 1));
        send_cmd(make_cmd(ACT_DILATE, 0, 0, 0, 0, 6, 1));
        send_cmd(make_cmd(ACT_READ, 2, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_WRITE, 0, 0, 1, 127, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 1, 1, 0, 0, 0, 0));

        // Empty volumes on each axis, the unit volume, and full or oversized lines.
        run_phase(0, 4, 4, 12);
        run_phase(3, 0, 2, 12);
        run_phase(2, 2, 0, 12);
        run_phase(1, 1, 1, 20);
        run_phase(63, 1, 1, 40);
        run_phase(1, 32, 1, 40);
        run_phase(1, 1, 63, 40);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                axis = $urandom_range(0, 2);
                big  = $urandom_range(33, 63);
                sx = (axis == 0) ? big : 1;
                sy = (axis == 1) ? big : 1;
                sz = (axis == 2) ? big : 1;
            end else begin
                sx  = $urandom_range(1, 6);
                lim = 48 / sx;
                sy  = $urandom_range(1, (lim > 6) ? 6 : lim);
                lim = 48 / (sx * sy);
                sz  = $urandom_range(1, (lim > 6) ? 6 : lim);
            end
            run_phase(sx, sy, sz, $urandom_range(20, 60));
        end

        wait_idle();
        repeat (END_SETTLE) @(posedge aclk);
        if (sb.error_count == 0)
            $display("voxel_dilate_six_neighbour regression: pass");
        else
            $display("voxel_dilate_six_neighbour regression: fail");
        $finish;
    end
endmodule
